@@ rtl/skt_pkg.sv @@
// Shared types, codes and sizes for the sorted key table.
package skt_pkg;

    // Table size and derived widths
    localparam int CAPACITY    = 16;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // One stored pair
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } entry_t;

    // Port request to the entry store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    // Outcome of the shared key comparator
    typedef struct packed {
        logic less;
        logic equal;
    } cmp_res_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INS_RD,
        S_INS_MV,
        S_INS_WR,
        S_REM_RD,
        S_REM_MV,
        S_DONE
    } state_t;

endpackage

@@ rtl/skt_store.sv @@
// Entry store: one write port and one registered read port.
module skt_store (
    input  logic              clk,
    input  skt_pkg::mem_req_t req,
    output skt_pkg::entry_t   rd_data
);
    import skt_pkg::*;

    entry_t mem [CAPACITY];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ rtl/skt_cmp.sv @@
// Shared signed key comparator used on every scan step.
module skt_cmp (
    input  logic signed [skt_pkg::KEY_W-1:0] stored_key,
    input  logic signed [skt_pkg::KEY_W-1:0] search_key,
    output skt_pkg::cmp_res_t                res
);
    import skt_pkg::*;

    // Signed order and match of the stored key against the request key
    always_comb
    begin
        res.less  = stored_key < search_key;
        res.equal = stored_key == search_key;
    end

endmodule

@@ rtl/sorted_key_table.sv @@
// Top level: sequencer, count and result register of the sorted key table.
//
//   channel | signals                                               | direction
//   --------+-------------------------------------------------------+----------
//   request | in_valid in_ready mode item_key item_value            | in
//   result  | out_valid out_ready status read_value entry_count_out | out
//
// A request is taken in the idle cycle, then the store is scanned from entry 0,
// each entry read and then compared, through the single read port and the
// shared comparator. An insert then moves each later entry up, a read and a
// move per entry, and writes the pair; a remove moves each later entry down
// likewise. A full reject or an unused mode skips the scan. The result becomes
// valid in the same cycle as the sequencer returns to idle and can take the
// next request. Reset clears the count, the output valid flag and the
// sequencer only; the store is not cleared. A stalled result holds in the
// output register while the next request is taken; the sequencer waits at
// its end if that register is still full.
module sorted_key_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [skt_pkg::MODE_W-1:0]          mode,
    input  logic signed [skt_pkg::KEY_W-1:0]    item_key,
    input  logic [skt_pkg::VAL_W-1:0]           item_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [skt_pkg::STATUS_W-1:0]        status,
    output logic [skt_pkg::VAL_W-1:0]           read_value,
    output logic [skt_pkg::COUNT_OUT_W-1:0]     entry_count_out
);
    import skt_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      mv_reg, mv_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0]      value_reg, value_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [VAL_W-1:0]      res_value_reg, res_value_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VAL_W-1:0]      read_value_reg, read_value_next;
    logic [CNT_W-1:0]      count_out_reg, count_out_next;

    mem_req_t mem_req;
    entry_t   rd_data;
    cmp_res_t cmp;

    skt_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    skt_cmp u_cmp (
        .stored_key (rd_data.key),
        .search_key (key_reg),
        .res        (cmp)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        mv_reg         <= mv_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        count_out_reg  <= count_out_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mv_next         = mv_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        count_out_next  = count_out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = item_key;
                    value_next      = item_value;
                    idx_next        = '0;
                    res_status_next = ST_DONE;
                    res_value_next  = '0;
                    if (mode == MODE_INSERT && count_reg == CNT_W'(CAPACITY))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else if (mode == MODE_INSERT || mode == MODE_REMOVE || mode == MODE_GET)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Issue the read of the next entry, or stop at the end of the table
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        mv_next    = count_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[ADDR_W-1:0];
                    state_next      = S_SCAN_CMP;
                end
            end

            // Compare the entry read against the request key
            S_SCAN_CMP:
            begin
                if (cmp.less)
                begin
                    idx_next   = CNT_W'(idx_reg + 1'b1);
                    state_next = S_SCAN_RD;
                end
                else if (mode_reg == MODE_INSERT)
                begin
                    mv_next    = count_reg;
                    state_next = S_INS_RD;
                end
                else if (cmp.equal && mode_reg == MODE_GET)
                begin
                    res_value_next = rd_data.value;
                    state_next     = S_DONE;
                end
                else if (cmp.equal)
                begin
                    mv_next    = idx_reg;
                    state_next = S_REM_RD;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            // Insert: open a gap at the slot by moving entries up
            S_INS_RD:
            begin
                if (mv_reg == idx_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(mv_reg - 1'b1);
                    state_next      = S_INS_MV;
                end
            end

            S_INS_MV:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = mv_reg[ADDR_W-1:0];
                mem_req.wr_data = rd_data;
                mv_next         = CNT_W'(mv_reg - 1'b1);
                state_next      = S_INS_RD;
            end

            S_INS_WR:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = idx_reg[ADDR_W-1:0];
                mem_req.wr_data.key   = key_reg;
                mem_req.wr_data.value = value_reg;
                count_next            = CNT_W'(count_reg + 1'b1);
                state_next            = S_DONE;
            end

            // Remove: close the gap by moving entries down
            S_REM_RD:
            begin
                if (CNT_W'(mv_reg + 1'b1) == count_reg)
                begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(mv_reg + 1'b1);
                    state_next      = S_REM_MV;
                end
            end

            S_REM_MV:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = mv_reg[ADDR_W-1:0];
                mem_req.wr_data = rd_data;
                mv_next         = CNT_W'(mv_reg + 1'b1);
                state_next      = S_REM_RD;
            end

            // Hand the result over once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    status_next     = res_status_reg;
                    read_value_next = res_value_reg;
                    count_out_next  = count_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign read_value      = read_value_reg;
    assign entry_count_out = COUNT_OUT_W'(count_out_reg);

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A full result is only given with the table at capacity
    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (entry_count_out == COUNT_OUT_W'(CAPACITY)))
        else $error("full status with room in the table");

    // The count only moves at the end of an insert or a remove
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == S_INS_WR || $past(state_reg) == S_REM_RD))
        else $error("entry count changed outside insert or remove");

    // Moves never write beyond the held entries, but for the slot just past them on an insert
    a_move_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_MV || state_reg == S_REM_MV) |-> (mv_reg < count_reg
            || (state_reg == S_INS_MV && mv_reg == count_reg)))
        else $error("entry move outside the table");

    // A successful get returns with a done status
    a_get_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CMP && !cmp.less && cmp.equal && mode_reg == MODE_GET)
            |=> (state_reg == S_DONE && res_status_reg == ST_DONE))
        else $error("get hit without done status");

endmodule
